// ===== rtl/block_average_pixelation_defines.svh =====
// Assertion macros shared by the block average pixelation RTL.
// No dependencies; included by the files that carry assertions.
`ifndef BLOCK_AVERAGE_PIXELATION_DEFINES_SVH
`define BLOCK_AVERAGE_PIXELATION_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled while reset is high
`define BAP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset
`define BAP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BAP_ASSERT(lbl, clk, rst, prop, msg)
`define BAP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/bap_pkg.sv =====
// Shared types and constants for the block average pixelation block.
// No dependencies.
package bap_pkg;

  // Fixed field and port widths
  localparam int PIXEL_W     = 8;
  localparam int MEAN_W      = 8;
  localparam int BROW_W      = 12;
  localparam int BCOL_W      = 10;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int BLOCK_REG_W  = 5;

  // Register reset values
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd1024;
  localparam logic [BLOCK_REG_W-1:0]  BLOCK_RESET  = 5'd8;

  // Register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_BLOCK_SIZE   = 2'd2
  } cfg_reg_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_PUSH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;       // capture pixel, start column sum read
    logic acc;        // update column sum, advance position
    logic div_start;  // launch mean division
    logic load_out;   // move quotient into output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic block_done; // current pixel closes its block
    logic div_done;   // quotient ready
    logic out_free;   // output register can take a new result
  } sts_t;

endpackage

// ===== rtl/block_average_pixelation.sv =====
// Top level of the block average pixelation block: controller plus datapath.
// Depends on bap_pkg, bap_ctrl, bap_datapath (and bap_div below it).
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  input    | in_valid / in_ready   | pixel
//  output   | out_valid / out_ready | block_mean, block_row, block_col, frame_last
//  config   | cfg_write             | cfg_index, cfg_data
//
// A pixel that does not close a block is accepted, then gets a
// read-modify-write of its column sum in the block column memory.
// A pixel that closes a block also goes through the 8-step bit-serial divider,
// and then its result is loaded into the output register.
// The output register holds one result; the controller waits before loading
// it only while a previous result is still untaken.
// Reset (rst, synchronous) clears position and control; the column sum memory
// is not cleared, since every block's first pixel overwrites its entry.
module block_average_pixelation #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_BLOCK  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [bap_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bap_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bap_pkg::PIXEL_W-1:0]     pixel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bap_pkg::MEAN_W-1:0]      block_mean,
  output logic [bap_pkg::BROW_W-1:0]      block_row,
  output logic [bap_pkg::BCOL_W-1:0]      block_col,
  output logic                            frame_last
);

  bap_pkg::cmd_t cmd;
  bap_pkg::sts_t sts;

  bap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bap_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_BLOCK  (MAX_BLOCK)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel      (pixel),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .block_mean (block_mean),
    .block_row  (block_row),
    .block_col  (block_col),
    .frame_last (frame_last)
  );

endmodule

// ===== rtl/bap_div.sv =====
// Restoring divider, one quotient bit per cycle, 8-bit quotient.
// Depends on block_average_pixelation_defines.svh.
`include "block_average_pixelation_defines.svh"

module bap_div #(
  parameter int SUM_W = 20,
  parameter int CNT_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic [7:0]       quotient,
  output logic             done
);

  localparam int SD_W = CNT_W + 7;
  localparam int TW   = (SUM_W > SD_W) ? SUM_W : SD_W;

  logic [SUM_W-1:0] rem;
  logic [SD_W-1:0]  sd;
  logic [CNT_W-1:0] dvs;
  logic [2:0]       step;
  logic             busy;
  logic             fits;

  assign fits = TW'(rem) >= TW'(sd);

  // Control: busy for eight steps, done pulses after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 3'd0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: trial subtract of the shifted divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      sd       <= {divisor, 7'd0};
      dvs      <= divisor;
      quotient <= 8'd0;
    end else if (busy) begin
      if (fits) begin
        rem <= SUM_W'(TW'(rem) - TW'(sd));
      end
      quotient <= {quotient[6:0], fits};
      sd       <= sd >> 1;
    end
  end

  `BAP_ASSERT(a_rem_below_divisor, clk, rst, done |-> (TW'(rem) < TW'(dvs)), "remainder not below divisor")

endmodule

// ===== rtl/bap_datapath.sv =====
// Datapath: config registers, raster position, column sum memory,
// divider and output register. Depends on bap_pkg and bap_div.
module bap_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_BLOCK  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [bap_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bap_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [bap_pkg::PIXEL_W-1:0]       pixel,
  input  bap_pkg::cmd_t                     cmd,
  output bap_pkg::sts_t                     sts,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [bap_pkg::MEAN_W-1:0]        block_mean,
  output logic [bap_pkg::BROW_W-1:0]        block_row,
  output logic [bap_pkg::BCOL_W-1:0]        block_col,
  output logic                              frame_last
);

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int BW    = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int WEW   = $clog2(MAX_WIDTH + 1);
  localparam int HEW   = $clog2(MAX_HEIGHT + 1);
  localparam int BEW   = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W = $clog2(255 * MAX_BLOCK * MAX_BLOCK + 1);
  localparam int CNT_W = $clog2(MAX_BLOCK * MAX_BLOCK + 1);

  // Config registers
  logic [bap_pkg::WIDTH_REG_W-1:0]  width_reg;
  logic [bap_pkg::HEIGHT_REG_W-1:0] height_reg;
  logic [bap_pkg::BLOCK_REG_W-1:0]  block_reg;
  logic                             restart;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= bap_pkg::WIDTH_RESET;
      height_reg <= bap_pkg::HEIGHT_RESET;
      block_reg  <= bap_pkg::BLOCK_RESET;
    end else if (cfg_write) begin
      unique case (bap_pkg::cfg_reg_t'(cfg_index))
        bap_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data[bap_pkg::WIDTH_REG_W-1:0];
        bap_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data[bap_pkg::HEIGHT_REG_W-1:0];
        bap_pkg::REG_BLOCK_SIZE:   block_reg  <= cfg_data[bap_pkg::BLOCK_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Any write to a known register restarts the frame
  always_comb begin
    restart = 1'b0;
    if (cfg_write) begin
      unique case (bap_pkg::cfg_reg_t'(cfg_index))
        bap_pkg::REG_IMAGE_WIDTH,
        bap_pkg::REG_IMAGE_HEIGHT,
        bap_pkg::REG_BLOCK_SIZE: restart = 1'b1;
        default:                 restart = 1'b0;
      endcase
    end
  end

  // Clamped values in use
  logic [WEW-1:0] w_eff;
  logic [HEW-1:0] h_eff;
  logic [BEW-1:0] bs_eff;

  always_comb begin
    if (width_reg == '0)                    w_eff = WEW'(1);
    else if (32'(width_reg) > MAX_WIDTH)    w_eff = WEW'(MAX_WIDTH);
    else                                    w_eff = WEW'(width_reg);
    if (height_reg == '0)                   h_eff = HEW'(1);
    else if (32'(height_reg) > MAX_HEIGHT)  h_eff = HEW'(MAX_HEIGHT);
    else                                    h_eff = HEW'(height_reg);
    if (block_reg == '0)                    bs_eff = BEW'(1);
    else if (32'(block_reg) > MAX_BLOCK)    bs_eff = BEW'(MAX_BLOCK);
    else                                    bs_eff = BEW'(block_reg);
  end

  // Raster position of the next pixel
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [BW-1:0] col_in_block;
  logic [BW-1:0] row_in_band;
  logic [CW-1:0] block_col_index;
  logic [RW-1:0] block_row_index;

  logic last_col, last_row, block_right, block_bottom, block_first;

  assign last_col     = (32'(col_count) + 32'd1) >= 32'(w_eff);
  assign last_row     = (32'(row_count) + 32'd1) >= 32'(h_eff);
  assign block_right  = last_col || ((32'(col_in_block) + 32'd1) >= 32'(bs_eff));
  assign block_bottom = last_row || ((32'(row_in_band) + 32'd1) >= 32'(bs_eff));
  assign block_first  = (row_in_band == '0) && (col_in_block == '0);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_count       <= '0;
      row_count       <= '0;
      col_in_block    <= '0;
      row_in_band     <= '0;
      block_col_index <= '0;
      block_row_index <= '0;
    end else if (cmd.acc) begin
      if (last_col) begin
        col_count       <= '0;
        col_in_block    <= '0;
        block_col_index <= '0;
        if (last_row) begin
          row_count       <= '0;
          row_in_band     <= '0;
          block_row_index <= '0;
        end else begin
          row_count <= row_count + RW'(1);
          if (block_bottom) begin
            row_in_band     <= '0;
            block_row_index <= block_row_index + RW'(1);
          end else begin
            row_in_band <= row_in_band + BW'(1);
          end
        end
      end else begin
        col_count <= col_count + CW'(1);
        if (block_right) begin
          col_in_block    <= '0;
          block_col_index <= block_col_index + CW'(1);
        end else begin
          col_in_block <= col_in_block + BW'(1);
        end
      end
    end
  end

  // Column sum memory: read on take, write back on acc
  logic [SUM_W-1:0]            col_mem [MAX_WIDTH];
  logic [SUM_W-1:0]            rd_sum;
  logic [bap_pkg::PIXEL_W-1:0] pix_q;
  logic [SUM_W-1:0]            new_sum;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rd_sum <= col_mem[block_col_index];
      pix_q  <= pixel;
    end
    if (cmd.acc) begin
      col_mem[block_col_index] <= new_sum;
    end
  end

  assign new_sum = block_first ? SUM_W'(pix_q) : rd_sum + SUM_W'(pix_q);

  // Pixel count of the closing block
  logic [CNT_W-1:0] pix_cnt;
  assign pix_cnt = CNT_W'((32'(col_in_block) + 32'd1) * (32'(row_in_band) + 32'd1));

  logic [7:0] quotient;
  logic       div_done;

  bap_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (new_sum),
    .divisor  (pix_cnt),
    .quotient (quotient),
    .done     (div_done)
  );

  // Coordinates of the block under division
  logic [bap_pkg::BROW_W-1:0] row_pend;
  logic [bap_pkg::BCOL_W-1:0] col_pend;
  logic                       last_pend;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      row_pend  <= bap_pkg::BROW_W'(block_row_index);
      col_pend  <= bap_pkg::BCOL_W'(block_col_index);
      last_pend <= last_col && last_row;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      block_mean <= quotient;
      block_row  <= row_pend;
      block_col  <= col_pend;
      frame_last <= last_pend;
    end
  end

  // Status to controller
  assign sts.block_done = block_right && block_bottom;
  assign sts.div_done   = div_done;
  assign sts.out_free   = !out_valid || out_ready;

endmodule

// ===== rtl/bap_ctrl.sv =====
// Controller state machine sequencing pixel accumulate, divide and output.
// Depends on bap_pkg and block_average_pixelation_defines.svh.
`include "block_average_pixelation_defines.svh"

module bap_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bap_pkg::sts_t sts,
  output bap_pkg::cmd_t cmd
);

  bap_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bap_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      bap_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = bap_pkg::ST_ACC;
        end
      end
      bap_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
        if (sts.block_done) begin
          cmd.div_start = 1'b1;
          state_next    = bap_pkg::ST_DIV;
        end else begin
          state_next = bap_pkg::ST_IDLE;
        end
      end
      bap_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_next = bap_pkg::ST_PUSH;
        end
      end
      bap_pkg::ST_PUSH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = bap_pkg::ST_IDLE;
        end
      end
      default: state_next = bap_pkg::ST_IDLE;
    endcase
  end

  `BAP_ASSERT(a_done_in_div, clk, rst, sts.div_done |-> (state == bap_pkg::ST_DIV), "quotient ready outside divide state")
  `BAP_ASSERT(a_load_free, clk, rst, cmd.load_out |-> sts.out_free, "output loaded while occupied")

endmodule
